@@ hw/rtl/fbpa_pkg.sv @@
package fbpa_pkg;

    localparam int unsigned MAX_BLOCKS = 1024;
    localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CMP_W      = (CNT_W > 11) ? CNT_W : 11;
    localparam int unsigned PROD_W     = CNT_W + 16;

    localparam int unsigned RESET_BLOCKS = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;

    localparam logic [2:0] REG_BASE_ADDRESS = 3'd0;
    localparam logic [2:0] REG_REGION_BYTES = 3'd1;
    localparam logic [2:0] REG_BLOCK_BYTES  = 3'd2;
    localparam logic [2:0] REG_MAX_ALIGN    = 3'd3;
    localparam logic [2:0] REG_NUM_BLOCKS   = 3'd4;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_FREE_ALL = 2'd2,
        CMD_RESIZE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_BADREQ = 3'd2,
        ST_NULL   = 3'd3,
        ST_BOUNDS = 3'd4,
        ST_FULL   = 3'd5,
        ST_BIG    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        OP_DONE,
        OP_ALLOC,
        OP_FREE,
        OP_FREE_ALL
    } op_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] request_size;
        logic [31:0] request_align;
        logic [31:0] block_address;
        logic [31:0] resize_bytes;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] granted_address;
        status_t     status;
    } resp_t;

    typedef struct packed {
        logic [31:0] base_address;
        logic [31:0] region_bytes;
        logic [15:0] block_bytes;
        logic [12:0] max_align;
        logic [10:0] num_blocks;
    } cfg_t;

    // classified request handed from front to back
    typedef struct packed {
        op_t         op;
        status_t     status;
        logic [31:0] addr;
    } work_t;

    function automatic logic [CNT_W-1:0] eff_blocks(input logic [10:0] count);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(count);
        if (wide > CMP_W'(MAX_BLOCKS))
            return CNT_W'(MAX_BLOCKS);
        return CNT_W'(count);
    endfunction

endpackage

@@ hw/rtl/fbpa_ram.sv @@
module fbpa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/fbpa_front.sv @@
module fbpa_front (
    input  logic            clk,
    input  logic            rst_n,
    input  fbpa_pkg::cfg_t  cfg,
    input  logic            push,
    input  fbpa_pkg::req_t  req,
    output logic            full,
    output logic            work_valid,
    output fbpa_pkg::work_t work,
    input  logic            work_take
);
    import fbpa_pkg::*;

    logic        bad_req;
    logic        is_null;
    logic        in_region;
    logic [32:0] region_end;
    work_t       item;
    logic        push_xfer;

    work_t       q_mem_reg [2];
    logic        q_wr_reg;
    logic        q_wr_next;
    logic        q_rd_reg;
    logic        q_rd_next;
    logic [1:0]  q_cnt_reg;
    logic [1:0]  q_cnt_next;

    // stateless checks, resolved before the item is queued
    always_comb
    begin
        bad_req = (req.request_size > 32'(cfg.block_bytes))
               || (req.request_align == 32'd0)
               || (req.request_align > 32'(cfg.max_align));
        is_null    = (req.block_address == 32'd0);
        region_end = {1'b0, cfg.base_address} + {1'b0, cfg.region_bytes};
        in_region  = (req.block_address >= cfg.base_address)
                  && ({1'b0, req.block_address} < region_end);

        item.op     = OP_DONE;
        item.status = ST_OK;
        item.addr   = req.block_address;
        case (req.cmd)
            CMD_ALLOC:
            begin
                if (bad_req)
                    item.status = ST_BADREQ;
                else
                    item.op = OP_ALLOC;
            end
            CMD_FREE:
            begin
                if (is_null)
                    item.status = ST_NULL;
                else if (!in_region)
                    item.status = ST_BOUNDS;
                else
                    item.op = OP_FREE;
            end
            CMD_FREE_ALL:
            begin
                item.op = OP_FREE_ALL;
            end
            CMD_RESIZE:
            begin
                if (is_null)
                    item.status = ST_NULL;
                else if (!in_region)
                    item.status = ST_BOUNDS;
                else if (req.resize_bytes > 32'(cfg.block_bytes))
                    item.status = ST_BIG;
            end
            default:
            begin
                item.op = OP_DONE;
            end
        endcase
    end

    assign full       = (q_cnt_reg == 2'd2);
    assign push_xfer  = push && !full;
    assign work_valid = (q_cnt_reg != 2'd0);
    assign work       = q_mem_reg[q_rd_reg];

    always_comb
    begin
        q_wr_next  = push_xfer ? ~q_wr_reg : q_wr_reg;
        q_rd_next  = work_take ? ~q_rd_reg : q_rd_reg;
        q_cnt_next = q_cnt_reg;
        case ({push_xfer, work_take})
            2'b10:   q_cnt_next = q_cnt_reg + 2'd1;
            2'b01:   q_cnt_next = q_cnt_reg - 2'd1;
            default: q_cnt_next = q_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= 1'b0;
            q_rd_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            q_wr_reg  <= q_wr_next;
            q_rd_reg  <= q_rd_next;
            q_cnt_reg <= q_cnt_next;
            if (push_xfer)
                q_mem_reg[q_wr_reg] <= item;
        end
    end

endmodule

@@ hw/rtl/fbpa_back.sv @@
module fbpa_back (
    input  logic            clk,
    input  logic            rst_n,
    input  fbpa_pkg::cfg_t  cfg,
    input  logic            work_valid,
    input  fbpa_pkg::work_t work,
    output logic            work_take,
    output fbpa_pkg::resp_t resp,
    output logic            empty,
    input  logic            pop
);
    import fbpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_ADDR
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    stack_cnt_reg;
    logic [CNT_W-1:0]    stack_cnt_next;
    logic [CNT_W-1:0]    untouched_reg;
    logic [CNT_W-1:0]    untouched_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;

    resp_t               out_mem_reg [2];
    logic                out_wr_reg;
    logic                out_rd_reg;
    logic [1:0]          out_cnt_reg;
    logic [1:0]          out_cnt_next;
    logic                out_full;
    logic                pop_xfer;

    logic [CNT_W-1:0]    eff;
    logic [CNT_W:0]      occupied;
    logic                list_full;
    logic [CNT_W-1:0]    stack_dec;
    logic [CNT_W-1:0]    untouched_dec;

    logic                res_push;
    resp_t               res;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    logic [31:0]         ram_rdata;

    fbpa_ram #(
        .WIDTH (32),
        .DEPTH (MAX_BLOCKS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (work.addr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_full  = (out_cnt_reg == 2'd2);
    assign empty     = (out_cnt_reg == 2'd0);
    assign pop_xfer  = pop && !empty;
    assign resp      = out_mem_reg[out_rd_reg];
    assign work_take = (state_reg == S_IDLE) && work_valid && !out_full;

    always_comb
    begin
        eff           = eff_blocks(cfg.num_blocks);
        occupied      = {1'b0, stack_cnt_reg} + {1'b0, untouched_reg};
        list_full     = (occupied >= (CNT_W+1)'(eff))
                     || (stack_cnt_reg >= CNT_W'(MAX_BLOCKS));
        stack_dec     = stack_cnt_reg - CNT_W'(1);
        untouched_dec = untouched_reg - CNT_W'(1);
        ram_waddr     = stack_cnt_reg[IDX_W-1:0];
        ram_raddr     = stack_dec[IDX_W-1:0];
        ram_we        = 1'b0;

        state_next     = state_reg;
        stack_cnt_next = stack_cnt_reg;
        untouched_next = untouched_reg;
        prod_next      = prod_reg;
        res_push       = 1'b0;
        res.ok              = 1'b1;
        res.granted_address = 32'd0;
        res.status          = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (work_take)
                begin
                    case (work.op)
                        OP_DONE:
                        begin
                            res_push   = 1'b1;
                            res.status = work.status;
                            res.ok     = (work.status == ST_OK);
                        end
                        OP_FREE_ALL:
                        begin
                            res_push       = 1'b1;
                            stack_cnt_next = '0;
                            untouched_next = eff;
                        end
                        OP_FREE:
                        begin
                            res_push = 1'b1;
                            if (list_full)
                            begin
                                res.status = ST_FULL;
                                res.ok     = 1'b0;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                stack_cnt_next = stack_cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_ALLOC:
                        begin
                            // freed blocks first, then untouched ones top down
                            if (stack_cnt_reg != '0)
                            begin
                                stack_cnt_next = stack_dec;
                                state_next     = S_READ;
                            end
                            else if (untouched_reg != '0)
                            begin
                                untouched_next = untouched_dec;
                                prod_next      = PROD_W'(untouched_dec)
                                               * PROD_W'(cfg.block_bytes);
                                state_next     = S_ADDR;
                            end
                            else
                            begin
                                res_push   = 1'b1;
                                res.status = ST_EMPTY;
                                res.ok     = 1'b0;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_push            = 1'b1;
                res.granted_address = ram_rdata;
                state_next          = S_IDLE;
            end
            S_ADDR:
            begin
                res_push            = 1'b1;
                res.granted_address = cfg.base_address + 32'(prod_reg);
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_cnt_next = out_cnt_reg;
        case ({res_push, pop_xfer})
            2'b10:   out_cnt_next = out_cnt_reg + 2'd1;
            2'b01:   out_cnt_next = out_cnt_reg - 2'd1;
            default: out_cnt_next = out_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stack_cnt_reg <= '0;
            untouched_reg <= CNT_W'(RESET_BLOCKS);
            out_wr_reg    <= 1'b0;
            out_rd_reg    <= 1'b0;
            out_cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            stack_cnt_reg <= stack_cnt_next;
            untouched_reg <= untouched_next;
            prod_reg      <= prod_next;
            out_cnt_reg   <= out_cnt_next;
            if (res_push)
            begin
                out_mem_reg[out_wr_reg] <= res;
                out_wr_reg              <= ~out_wr_reg;
            end
            if (pop_xfer)
                out_rd_reg <= ~out_rd_reg;
        end
    end

endmodule

@@ hw/rtl/fixed_block_pool_allocator_core.sv @@
// channel   | handshake              | payload
// ----------+------------------------+-----------------------------------
// request   | push / full            | req  (cmd, sizes, align, address)
// result    | empty / pop            | resp (ok, granted_address, status)
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a request is registered in the request queue, then its result in the result queue;
// an allocate that succeeds passes through a read or address state in between.
// the back end takes one request per cycle while the result queue has room, and not
// in that state (stack memory read, or index times block size then add).
// reset empties both queues and the freed stack; the stack memory is not cleared.
// either side may stall: a two-entry queue sits on each side of the back end.
module fixed_block_pool_allocator_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fbpa_pkg::req_t  req,
    output logic            full,
    output logic            empty,
    input  logic            pop,
    output fbpa_pkg::resp_t resp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import fbpa_pkg::*;

    cfg_t  cfg_reg;
    logic  work_valid;
    work_t work;
    logic  work_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_address <= 32'd0;
            cfg_reg.region_bytes <= 32'd65536;
            cfg_reg.block_bytes  <= 16'd64;
            cfg_reg.max_align    <= 13'd8;
            cfg_reg.num_blocks   <= 11'd1024;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_ADDRESS: cfg_reg.base_address <= cfg_data;
                REG_REGION_BYTES: cfg_reg.region_bytes <= cfg_data;
                REG_BLOCK_BYTES:  cfg_reg.block_bytes  <= cfg_data[15:0];
                REG_MAX_ALIGN:    cfg_reg.max_align    <= cfg_data[12:0];
                REG_NUM_BLOCKS:   cfg_reg.num_blocks   <= cfg_data[10:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    fbpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .req        (req),
        .full       (full),
        .work_valid (work_valid),
        .work       (work),
        .work_take  (work_take)
    );

    fbpa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .work_valid (work_valid),
        .work       (work),
        .work_take  (work_take),
        .resp       (resp),
        .empty      (empty),
        .pop        (pop)
    );

`ifndef SYNTH
    a_fail_no_address: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !resp.ok) |-> (resp.granted_address == 32'd0))
        else $error("failed result carries an address");

    a_ok_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (resp.ok == (resp.status == ST_OK)))
        else $error("ok flag disagrees with status");

    a_idle_queue_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !full) |=> !(empty && full))
        else $error("request queue filled in one cycle");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import fbpa_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 80;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    req_t        req       = '0;
    logic        full;
    logic        empty;
    logic        pop       = 1'b0;
    resp_t       resp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // mirror of the pool registers
    logic [31:0] pool_base   = 32'd0;
    logic [31:0] pool_region = 32'd65536;
    logic [15:0] pool_bsize  = 16'd64;
    logic [12:0] pool_align  = 13'd8;
    logic [10:0] pool_count  = 11'd1024;

    // mirror of the free list
    logic [31:0] freed_addr [0:MAX_BLOCKS-1];
    int unsigned stack_cnt = 0;
    int unsigned fresh_cnt = MAX_BLOCKS;

    req_t        request_queue [$];
    resp_t       awaited_results [$];

    int unsigned requests_sent = 0;
    int unsigned settings_used = 1;
    int unsigned fault_count   = 0;
    int unsigned cmd_seen [0:3];
    int unsigned status_seen [0:7];

    int unsigned send_gap    = 0;
    int unsigned send_steady = 0;
    int unsigned pop_gap     = 0;
    int unsigned pop_steady  = 0;
    int unsigned quiet_cycles = 0;
    logic        hold_pop    = 1'b0;

    fixed_block_pool_allocator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .req       (req),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .resp      (resp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        foreach (cmd_seen[i]) cmd_seen[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int unsigned idle_length(inout int unsigned steady_left);
        int unsigned r;
        if (steady_left > 0)
        begin
            steady_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            steady_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // expected outcome of one request; updates the mirrored free list
    function automatic resp_t pool_response(input req_t r);
        resp_t       o;
        int unsigned usable;
        logic [63:0] span_end;
        bit          in_pool;
        usable   = (pool_count > MAX_BLOCKS) ? MAX_BLOCKS : pool_count;
        span_end = {32'd0, pool_base} + {32'd0, pool_region};
        in_pool  = (r.block_address >= pool_base) && ({32'd0, r.block_address} < span_end);
        o        = '0;
        o.status = ST_OK;
        case (r.cmd)
            CMD_ALLOC:
            begin
                if (r.request_size > {16'd0, pool_bsize} || r.request_align == 32'd0 ||
                    r.request_align > {19'd0, pool_align})
                    o.status = ST_BADREQ;
                else if (stack_cnt > 0 && stack_cnt <= MAX_BLOCKS)
                begin
                    stack_cnt--;
                    o.granted_address = freed_addr[stack_cnt];
                end
                else if (fresh_cnt > 0)
                begin
                    fresh_cnt--;
                    o.granted_address = pool_base + fresh_cnt * pool_bsize;
                end
                else
                    o.status = ST_EMPTY;
            end
            CMD_FREE:
            begin
                if (r.block_address == 32'd0)
                    o.status = ST_NULL;
                else if (!in_pool)
                    o.status = ST_BOUNDS;
                else if (stack_cnt + fresh_cnt >= usable || stack_cnt >= MAX_BLOCKS)
                    o.status = ST_FULL;
                else
                begin
                    freed_addr[stack_cnt] = r.block_address;
                    stack_cnt++;
                end
            end
            CMD_FREE_ALL:
            begin
                stack_cnt = 0;
                fresh_cnt = usable;
            end
            default:
            begin
                if (r.block_address == 32'd0)
                    o.status = ST_NULL;
                else if (!in_pool)
                    o.status = ST_BOUNDS;
                else if (r.resize_bytes > {16'd0, pool_bsize})
                    o.status = ST_BIG;
            end
        endcase
        o.ok = (o.status == ST_OK);
        cmd_seen[r.cmd]++;
        status_seen[o.status]++;
        return o;
    endfunction

    function automatic logic [31:0] pick_address();
        int unsigned r;
        int unsigned span;
        r    = $urandom_range(0, 99);
        span = (pool_count == 0) ? 1 : ((pool_count > MAX_BLOCKS) ? MAX_BLOCKS : pool_count);
        if (r < 60)
            return pool_base + $urandom_range(0, span - 1) * pool_bsize;
        if (r < 70)
            return (pool_region == 0) ? pool_base : pool_base + ($urandom % pool_region);
        if (r < 78)
            return 32'd0;
        if (r < 86)
            return pool_base - 32'd1;
        if (r < 94)
            return pool_base + pool_region;
        return $urandom;
    endfunction

    function automatic req_t make_request();
        req_t        r;
        int unsigned pick;
        int unsigned sub;
        r.request_size  = $urandom;
        r.request_align = $urandom;
        r.block_address = $urandom;
        r.resize_bytes  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            r.cmd = CMD_ALLOC;
            sub = $urandom_range(0, 99);
            if (sub < 75)
                r.request_size = $urandom_range(0, pool_bsize);
            else if (sub < 88)
                r.request_size = 32'(pool_bsize) + 32'd1;
            sub = $urandom_range(0, 99);
            if (sub < 75)
                r.request_align = $urandom_range(1, pool_align);
            else if (sub < 83)
                r.request_align = 32'd0;
            else if (sub < 91)
                r.request_align = 32'(pool_align) + 32'd1;
        end
        else if (pick < 75)
        begin
            r.cmd = CMD_FREE;
            r.block_address = pick_address();
        end
        else if (pick < 78)
            r.cmd = CMD_FREE_ALL;
        else
        begin
            r.cmd = CMD_RESIZE;
            r.block_address = pick_address();
            sub = $urandom_range(0, 99);
            if (sub < 60)
                r.resize_bytes = $urandom_range(0, pool_bsize);
            else if (sub < 80)
                r.resize_bytes = 32'(pool_bsize) + 32'd1;
        end
        return r;
    endfunction

    task automatic queue_req(input cmd_t c, input logic [31:0] size, input logic [31:0] align,
                             input logic [31:0] addr, input logic [31:0] nsize);
        req_t r;
        r.cmd           = c;
        r.request_size  = size;
        r.request_align = align;
        r.block_address = addr;
        r.resize_bytes  = nsize;
        request_queue.push_back(r);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BASE_ADDRESS: pool_base   = val;
            REG_REGION_BYTES: pool_region = val;
            REG_BLOCK_BYTES:  pool_bsize  = val[15:0];
            REG_MAX_ALIGN:    pool_align  = val[12:0];
            REG_NUM_BLOCKS:   pool_count  = val[10:0];
            default: ;
        endcase
    endtask

    task automatic set_pool(input logic [31:0] base, input logic [31:0] region,
                            input logic [31:0] bsize, input logic [31:0] align,
                            input logic [31:0] count);
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_REGION_BYTES, region);
        write_reg(REG_BLOCK_BYTES, bsize);
        write_reg(REG_MAX_ALIGN, align);
        write_reg(REG_NUM_BLOCKS, count);
        settings_used++;
    endtask

    // queue a batch and wait until every result of it has been taken
    // sampled on the falling edge so the driver's updates have settled
    task automatic run_phase(input int unsigned n, input bit clear_first);
        if (clear_first)
            queue_req(CMD_FREE_ALL, 32'd0, 32'd0, 32'd0, 32'd0);
        repeat (n) request_queue.push_back(make_request());
        while (request_queue.size() != 0 || push || awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // request side
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                awaited_results.push_back(pool_response(req));
                requests_sent++;
            end
            if (!(push && full))
            begin
                if (send_gap > 0)
                begin
                    push <= 1'b0;
                    send_gap--;
                end
                else if (request_queue.size() != 0)
                begin
                    push     <= 1'b1;
                    req      <= request_queue.pop_front();
                    send_gap = idle_length(send_steady);
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk)
    begin : result_check
        resp_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected result: ok=%0b addr=%08h status=%0d",
                                 resp.ok, resp.granted_address, resp.status);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (resp.ok !== want.ok || resp.granted_address !== want.granted_address ||
                        resp.status !== want.status)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch: want %0b/%08h/%0d, got %0b/%08h/%0d",
                                     want.ok, want.granted_address, want.status,
                                     resp.ok, resp.granted_address, resp.status);
                    end
                end
            end
            if (hold_pop)
                pop <= 1'b0;
            else if (pop_gap > 0)
            begin
                pop <= 1'b0;
                pop_gap--;
            end
            else
            begin
                pop     <= 1'b1;
                pop_gap = idle_length(pop_steady);
            end
        end
    end

    // long receiver stall so the request side backs up
    initial
    begin
        wait (requests_sent >= 100);
        @(posedge clk);
        hold_pop <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pop <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("fixed_block_pool_allocator_core verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] rnd_base;
        logic [31:0] rnd_region;
        int unsigned rnd_bsize;
        int unsigned rnd_count;
        wait (rst_n);

        // reset settings: base 0, 64 byte blocks, alignment 8, 1024 blocks
        queue_req(CMD_ALLOC, 32'd64, 32'd8, 32'd0, 32'd0);
        queue_req(CMD_ALLOC, 32'd65, 32'd1, 32'd0, 32'd0);
        queue_req(CMD_ALLOC, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_req(CMD_ALLOC, 32'd1, 32'd9, 32'd0, 32'd0);
        queue_req(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        queue_req(CMD_ALLOC, 32'd0, 32'd1, 32'd0, 32'd0);
        queue_req(CMD_FREE, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_req(CMD_FREE, 32'd0, 32'd0, 32'h0001_0000, 32'd0);
        queue_req(CMD_FREE, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        queue_req(CMD_FREE, 32'd0, 32'd0, 32'h0000_FFC0, 32'd0);
        queue_req(CMD_FREE, 32'd0, 32'd0, 32'h0000_FF80, 32'd0);
        // list already holds every block: double free
        queue_req(CMD_FREE, 32'd0, 32'd0, 32'h0000_0040, 32'd0);
        queue_req(CMD_ALLOC, 32'd8, 32'd8, 32'd0, 32'd0);
        queue_req(CMD_RESIZE, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_req(CMD_RESIZE, 32'd0, 32'd0, 32'h0001_0000, 32'd0);
        queue_req(CMD_RESIZE, 32'd0, 32'd0, 32'h0000_0040, 32'd65);
        queue_req(CMD_RESIZE, 32'd0, 32'd0, 32'h0000_FFFF, 32'd64);
        queue_req(CMD_RESIZE, 32'd0, 32'd0, 32'h0000_0001, 32'hFFFF_FFFF);
        queue_req(CMD_FREE_ALL, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_req(CMD_FREE, 32'd0, 32'd0, 32'h0000_0040, 32'd0);
        queue_req(CMD_ALLOC, 32'd64, 32'd8, 32'd0, 32'd0);
        run_phase(220, 1'b0);

        // small pool that runs dry often
        set_pool(32'h0000_1000, 32'h0000_0400, 64, 8, 16);
        run_phase(220, 1'b1);

        // widest blocks, addresses wrap past the top, count above the maximum
        set_pool(32'hFFFF_F000, 32'hFFFF_FFFF, 65535, 8191, 2047);
        run_phase(220, 1'b1);

        // one-byte pool, free list counts kept from before until a free-all
        set_pool(32'h0000_0010, 32'd1, 1, 1, 1);
        run_phase(150, 1'b0);

        // no blocks at all
        set_pool(32'h0000_0100, 32'h0000_0100, 16, 4096, 0);
        run_phase(150, 1'b1);

        set_pool(32'hFFFF_FFFF, 32'd1, 65535, 0, 1024);
        run_phase(150, 1'b1);

        repeat (3)
        begin
            rnd_count  = $urandom_range(1, 48);
            rnd_bsize  = $urandom_range(1, 4096);
            rnd_base   = $urandom;
            rnd_region = rnd_count * rnd_bsize + $urandom_range(0, rnd_bsize);
            set_pool(rnd_base, rnd_region, rnd_bsize, $urandom_range(1, 4096), rnd_count);
            run_phase(150, 1'b1);
        end

        repeat (20) @(posedge clk);
        $display("%0d requests over %0d pool settings", requests_sent, settings_used);
        $display("commands: %0d alloc, %0d free, %0d free-all, %0d resize",
                 cmd_seen[CMD_ALLOC], cmd_seen[CMD_FREE],
                 cmd_seen[CMD_FREE_ALL], cmd_seen[CMD_RESIZE]);
        $display("outcomes: %0d ok, %0d empty, %0d bad request, %0d null, %0d out of bounds,",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BADREQ],
                 status_seen[ST_NULL], status_seen[ST_BOUNDS]);
        $display("          %0d list full, %0d too big; %0d faults",
                 status_seen[ST_FULL], status_seen[ST_BIG], fault_count);
        if (fault_count == 0 && awaited_results.size() == 0)
            $display("fixed_block_pool_allocator_core verification clean");
        else
            $display("fixed_block_pool_allocator_core verification failed");
        $finish;
    end

endmodule
